>>> rtl/core/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/dte_pkg.sv
package dte_pkg;

  localparam int ENTRIES_DEF  = 64;
  localparam int MAX_KEY_DEF  = 4;
  localparam int MAX_CODE_DEF = 4;

  typedef enum logic [1:0] {
    MODE_KEY  = 2'd0,
    MODE_CODE = 2'd1,
    MODE_LEN  = 2'd2,
    MODE_TEXT = 2'd3
  } mode_t;

  // Request handed from the front end to the match engine.
  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } text_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT,
    ST_FAIL,
    ST_DONE
  } eng_state_t;

endpackage

>>> rtl/core/dte_front.sv
// Front end: decodes requests, performs table writes, queues text characters.
module dte_front #(
  parameter int ENTRIES  = dte_pkg::ENTRIES_DEF,
  parameter int MAX_KEY  = dte_pkg::MAX_KEY_DEF,
  parameter int MAX_CODE = dte_pkg::MAX_CODE_DEF,
  parameter int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int KW = $clog2(MAX_KEY + 1),
  parameter int CW = $clog2(MAX_CODE + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                init_done,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [5:0]          entry_index,
  input  logic [1:0]          position,
  input  logic [7:0]          value,
  input  logic [2:0]          key_length,
  input  logic [2:0]          code_length,
  input  logic                end_of_text,
  // table write ports
  output logic                key_we,
  output logic [EW-1:0]       wr_entry,
  output logic [2:0]          wr_pos,
  output logic [7:0]          wr_data,
  output logic                code_we,
  output logic                len_we,
  output logic [KW-1:0]       wr_klen,
  output logic [CW-1:0]       wr_clen,
  // text queue toward the engine
  output logic                q_valid,
  input  logic                q_pop,
  output dte_pkg::text_req_t  q_head
);

  localparam int QD = 2;

  dte_pkg::text_req_t q_mem_r [QD];
  logic [0:0]         wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push, ent_ok, is_text;

  // Table writes wait until the text queue is empty; characters already in
  // the engine's lookahead window may not have been matched yet.
  assign is_text  = (dte_pkg::mode_t'(mode) == dte_pkg::MODE_TEXT);
  assign in_ready = init_done && (is_text ? (cnt_r != 2'(QD)) : (cnt_r == 2'd0));
  assign push     = in_valid && in_ready && is_text;
  assign ent_ok   = (32'(entry_index) < 32'(ENTRIES));

  assign wr_entry = EW'(entry_index);
  assign wr_pos   = 3'(position);
  assign wr_data  = value;
  assign key_we   = in_valid && in_ready && (dte_pkg::mode_t'(mode) == dte_pkg::MODE_KEY)
                    && ent_ok && (32'(position) < 32'(MAX_KEY));
  assign code_we  = in_valid && in_ready && (dte_pkg::mode_t'(mode) == dte_pkg::MODE_CODE)
                    && ent_ok && (32'(position) < 32'(MAX_CODE));
  assign len_we   = in_valid && in_ready && (dte_pkg::mode_t'(mode) == dte_pkg::MODE_LEN)
                    && ent_ok;
  assign wr_klen  = (32'(key_length) > 32'(MAX_KEY)) ? KW'(MAX_KEY) : KW'(key_length);
  assign wr_clen  = (32'(code_length) > 32'(MAX_CODE)) ? CW'(MAX_CODE) : CW'(code_length);

  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{eot: end_of_text, ch: value};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

>>> rtl/core/dte_engine.sv
// Match engine: keeps the lookahead window, scans the table one entry per
// cycle, and emits code bytes or an error result.
module dte_engine #(
  parameter int ENTRIES  = dte_pkg::ENTRIES_DEF,
  parameter int MAX_KEY  = dte_pkg::MAX_KEY_DEF,
  parameter int MAX_CODE = dte_pkg::MAX_CODE_DEF,
  parameter int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int KW = $clog2(MAX_KEY + 1),
  parameter int CW = $clog2(MAX_CODE + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  output logic                init_done,
  input  logic                key_we,
  input  logic [EW-1:0]       wr_entry,
  input  logic [2:0]          wr_pos,
  input  logic [7:0]          wr_data,
  input  logic                code_we,
  input  logic                len_we,
  input  logic [KW-1:0]       wr_klen,
  input  logic [CW-1:0]       wr_clen,
  input  logic                q_valid,
  output logic                q_pop,
  input  dte_pkg::text_req_t  q_head,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_code,
  output logic                out_err,
  output logic [7:0]          out_bad,
  output logic                out_last
);

  localparam int KPW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int CPW = (MAX_CODE > 1) ? $clog2(MAX_CODE) : 1;
  localparam int EW1 = $clog2(ENTRIES + 1);

  // Each entry's whole key (and code) is one memory row.
  logic [MAX_KEY*8-1:0]  key_mem  [ENTRIES];
  logic [MAX_CODE*8-1:0] code_mem [ENTRIES];
  logic [KW-1:0]         klen_r [ENTRIES];
  logic [CW-1:0]         clen_r [ENTRIES];

  logic [7:0]            win_r [MAX_KEY];
  logic [KW-1:0]         wcnt_r;
  logic                  disc_r, eot_r;
  logic [EW1-1:0]        idx_r;
  logic [EW1-1:0]        clr_r;
  logic [MAX_KEY*8-1:0]  krow_r;
  logic [MAX_CODE*8-1:0] crow_r;
  logic [KW-1:0]         kl_r;
  logic [CW-1:0]         cl_r;
  logic [CW-1:0]         bi_r;
  logic                  rd_ok_r;
  logic                  hold_r;
  logic [7:0]            hold_code_r;

  dte_pkg::eng_state_t st_r, st_nxt;

  logic hit, need, more, emit_fire, adv;

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_entry][8*wr_pos[KPW-1:0] +: 8] <= wr_data;
    if (code_we) code_mem[wr_entry][8*wr_pos[CPW-1:0] +: 8] <= wr_data;
  end

  // The fetched row is frozen once a hit is found so that the emit phase
  // works on the matching entry.
  always_ff @(posedge clk) begin
    if (st_r == dte_pkg::ST_SCAN && !(rd_ok_r && hit) && idx_r < EW1'(ENTRIES)) begin
      krow_r <= key_mem[idx_r[EW-1:0]];
      crow_r <= code_mem[idx_r[EW-1:0]];
      kl_r   <= klen_r[idx_r[EW-1:0]];
      cl_r   <= clen_r[idx_r[EW-1:0]];
    end
  end

  // After reset the length table is cleared one entry per cycle.
  assign init_done = (clr_r == EW1'(ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (!init_done) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!init_done) begin
      klen_r[clr_r[EW-1:0]] <= '0;
      clen_r[clr_r[EW-1:0]] <= '0;
    end else if (len_we) begin
      klen_r[wr_entry] <= wr_klen;
      clen_r[wr_entry] <= wr_clen;
    end
  end

  // Compare the fetched key row against the window head.
  always_comb begin
    hit = (kl_r != '0) && (kl_r <= wcnt_r);
    for (int i = 0; i < MAX_KEY; i++) begin
      if (KW'(i) < kl_r && krow_r[8*i +: 8] != win_r[i]) hit = 1'b0;
    end
  end

  assign need = (wcnt_r == KW'(MAX_KEY)) || (eot_r && wcnt_r != '0);
  assign more = (bi_r + 1'b1) < cl_r;
  assign emit_fire = out_valid && out_ready;
  // The newest code byte waits in the hold register until it is known
  // whether another result of the same request follows it.
  assign adv = !hold_r || emit_fire;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      dte_pkg::ST_IDLE:  if (q_valid) st_nxt = disc_r ? dte_pkg::ST_IDLE : dte_pkg::ST_CHECK;
      dte_pkg::ST_CHECK: st_nxt = need ? dte_pkg::ST_SCAN : dte_pkg::ST_DONE;
      dte_pkg::ST_SCAN: begin
        if (rd_ok_r && hit) st_nxt = (cl_r != '0) ? dte_pkg::ST_EMIT : dte_pkg::ST_CHECK;
        else if (idx_r == EW1'(ENTRIES) && !rd_ok_r) st_nxt = dte_pkg::ST_FAIL;
      end
      dte_pkg::ST_EMIT:  if (adv && !more) st_nxt = dte_pkg::ST_CHECK;
      dte_pkg::ST_FAIL:  if (emit_fire && !hold_r) st_nxt = dte_pkg::ST_IDLE;
      dte_pkg::ST_DONE:  if (adv) st_nxt = dte_pkg::ST_IDLE;
      default:           st_nxt = dte_pkg::ST_IDLE;
    endcase
  end

  // Window length left after the matched key is shifted out.
  logic [KW-1:0] rem;
  assign rem = wcnt_r - kl_r;

  always_comb begin
    out_valid = 1'b0;
    out_code  = '0;
    out_err   = 1'b0;
    out_bad   = '0;
    out_last  = 1'b0;
    q_pop     = 1'b0;
    unique case (st_r)
      dte_pkg::ST_IDLE: q_pop = q_valid && disc_r;
      dte_pkg::ST_EMIT: begin
        out_valid = hold_r;
        out_code  = hold_code_r;
      end
      dte_pkg::ST_FAIL: begin
        out_valid = 1'b1;
        if (hold_r) begin
          out_code = hold_code_r;
        end else begin
          out_err  = 1'b1;
          out_bad  = win_r[0];
          out_last = 1'b1;
        end
        q_pop = emit_fire && !hold_r;
      end
      dte_pkg::ST_DONE: begin
        out_valid = hold_r;
        out_code  = hold_code_r;
        out_last  = hold_r;
        q_pop     = adv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= dte_pkg::ST_IDLE;
      wcnt_r      <= '0;
      disc_r      <= 1'b0;
      eot_r       <= 1'b0;
      idx_r       <= '0;
      bi_r        <= '0;
      rd_ok_r     <= 1'b0;
      hold_r      <= 1'b0;
      hold_code_r <= '0;
      for (int i = 0; i < MAX_KEY; i++) win_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        dte_pkg::ST_IDLE: begin
          if (q_valid && disc_r) begin
            if (q_head.eot) begin
              disc_r <= 1'b0;
              wcnt_r <= '0;
            end
          end else if (q_valid) begin
            eot_r <= q_head.eot;
            if (wcnt_r < KW'(MAX_KEY)) begin
              win_r[wcnt_r[KPW-1:0]] <= q_head.ch;
              wcnt_r <= wcnt_r + 1'b1;
            end
          end
        end
        dte_pkg::ST_CHECK: begin
          idx_r   <= '0;
          rd_ok_r <= 1'b0;
        end
        dte_pkg::ST_SCAN: begin
          if (rd_ok_r && hit) begin
            bi_r <= '0;
            if (cl_r == '0) begin
              for (int i = 0; i < MAX_KEY; i++) begin
                if (KW'(i) + kl_r < KW'(MAX_KEY)) win_r[i] <= win_r[i + 32'(kl_r)];
              end
              wcnt_r <= rem;
            end
          end else begin
            rd_ok_r <= (idx_r < EW1'(ENTRIES));
            if (idx_r < EW1'(ENTRIES)) idx_r <= idx_r + 1'b1;
          end
        end
        dte_pkg::ST_EMIT: begin
          if (adv) begin
            hold_r      <= 1'b1;
            hold_code_r <= crow_r[8*bi_r[CPW-1:0] +: 8];
            bi_r        <= bi_r + 1'b1;
            if (!more) begin
              for (int i = 0; i < MAX_KEY; i++) begin
                if (KW'(i) + kl_r < KW'(MAX_KEY)) win_r[i] <= win_r[i + 32'(kl_r)];
              end
              wcnt_r <= rem;
            end
          end
        end
        dte_pkg::ST_FAIL: begin
          if (emit_fire) begin
            if (hold_r) begin
              hold_r <= 1'b0;
            end else begin
              wcnt_r <= '0;
              if (!eot_r) disc_r <= 1'b1;
            end
          end
        end
        dte_pkg::ST_DONE: begin
          if (emit_fire) hold_r <= 1'b0;
          if (eot_r) begin
            wcnt_r <= '0;
            disc_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/dte_outbuf.sv
// Output register between the engine and the result channel.
module dte_outbuf (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_valid,
  output logic        s_ready,
  input  logic [17:0] s_data,
  output logic        m_valid,
  input  logic        m_ready,
  output logic [17:0] m_data
);

  logic        vld_r;
  logic [17:0] dat_r;

  assign s_ready = !vld_r || m_ready;
  assign m_valid = vld_r;
  assign m_data  = dat_r;

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) dat_r <= s_data;
    if (!rst_n) vld_r <= 1'b0;
    else if (s_ready) vld_r <= s_valid;
  end

endmodule

>>> rtl/core/dictionary_text_encoder.sv
// Dictionary text encoder. Requests on the input stream either write the
// entry table (key characters, code bytes, lengths) or deliver text
// characters. After reset the length table is cleared one entry per cycle,
// so in_tready stays low until the clear is complete. Table writes produce
// no result, and a table write is only taken once the text queue is empty;
// characters still in the lookahead window may not be matched yet. Text
// characters go through a two-deep queue to a match engine that keeps a
// lookahead window of MAX_KEY characters. A character that does not trigger
// a scan enters the window, passes a check state and is then retired from
// the queue. Whenever the window is full or the string has ended, the
// engine scans the table one entry per cycle in index order, and the code
// bytes of a matched entry are then emitted one per cycle while the output
// is free. The newest code byte is held back until the engine knows whether
// another result of the same request follows, so that the final result can
// carry tlast. An unmatched character yields one error result and the rest
// of the string is dropped. Results leave through a one-stage output
// register.
module dictionary_text_encoder #(
  parameter int ENTRIES  = dte_pkg::ENTRIES_DEF,
  parameter int MAX_KEY  = dte_pkg::MAX_KEY_DEF,
  parameter int MAX_CODE = dte_pkg::MAX_CODE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: mode[1:0], entry_index[7:2], position[9:8], value[17:10],
  // key_length[20:18], code_length[23:21]; 0 above
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: code_byte[7:0], bad_char[15:8]
  output logic [15:0] out_tdata,
  output logic        out_tuser,  // no_entry
  output logic        out_tlast   // last
);

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW = $clog2(MAX_KEY + 1);
  localparam int CW = $clog2(MAX_CODE + 1);

  logic               key_we, code_we, len_we, q_valid, q_pop, init_done;
  logic [EW-1:0]      wr_entry;
  logic [2:0]         wr_pos;
  logic [7:0]         wr_data;
  logic [KW-1:0]      wr_klen;
  logic [CW-1:0]      wr_clen;
  dte_pkg::text_req_t q_head;
  logic               e_valid, e_ready, e_err, e_last;
  logic [7:0]         e_code, e_bad;
  logic [17:0]        ob_data;

  dte_front #(.ENTRIES(ENTRIES), .MAX_KEY(MAX_KEY), .MAX_CODE(MAX_CODE),
              .EW(EW), .KW(KW), .CW(CW)) u_front (
    .clk, .rst_n, .init_done,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .mode(in_tdata[1:0]), .entry_index(in_tdata[7:2]), .position(in_tdata[9:8]),
    .value(in_tdata[17:10]), .key_length(in_tdata[20:18]),
    .code_length(in_tdata[23:21]), .end_of_text(in_tlast),
    .key_we, .wr_entry, .wr_pos, .wr_data, .code_we, .len_we, .wr_klen, .wr_clen,
    .q_valid, .q_pop, .q_head
  );

  dte_engine #(.ENTRIES(ENTRIES), .MAX_KEY(MAX_KEY), .MAX_CODE(MAX_CODE),
               .EW(EW), .KW(KW), .CW(CW)) u_engine (
    .clk, .rst_n, .init_done,
    .key_we, .wr_entry, .wr_pos, .wr_data, .code_we, .len_we, .wr_klen, .wr_clen,
    .q_valid, .q_pop, .q_head,
    .out_valid(e_valid), .out_ready(e_ready), .out_code(e_code),
    .out_err(e_err), .out_bad(e_bad), .out_last(e_last)
  );

  dte_outbuf u_outbuf (
    .clk, .rst_n,
    .s_valid(e_valid), .s_ready(e_ready), .s_data({e_last, e_err, e_bad, e_code}),
    .m_valid(out_tvalid), .m_ready(out_tready), .m_data(ob_data)
  );

  assign out_tdata = ob_data[15:0];
  assign out_tuser = ob_data[16];
  assign out_tlast = ob_data[17];

endmodule

>>> rtl/core/dte_checker.sv
`include "assert_macros.svh"
// Port-level checks on the encoder.
module dte_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // An error result carries no code byte and always ends its request.
  `ASSERT_IMPL(err_is_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `ASSERT_IMPL(err_no_code, clk, rst_n, out_tvalid && out_tuser, out_tdata[7:0] == 8'd0)
  `ASSERT_IMPL(code_no_bad, clk, rst_n, out_tvalid && !out_tuser, out_tdata[15:8] == 8'd0)
  `ASSERT_NEXT(out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind dictionary_text_encoder dte_checker u_dte_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);
